### design/i2cd_pkg.sv
// ----------------------------------------------------------------------------
// I2C command decoder package
// Shared codes, result types and the version table of the command decoder.
// ----------------------------------------------------------------------------
package i2cd_pkg;

    localparam int NSLOT   = 5;
    localparam int RX_KEEP = 5;
    localparam int VER_LEN = 20;

    localparam logic [3:0] ACT_ADDR_RX   = 4'd0;
    localparam logic [3:0] ACT_ADDR_TX   = 4'd1;
    localparam logic [3:0] ACT_RX_BYTE   = 4'd2;
    localparam logic [3:0] ACT_TX_EMPTY  = 4'd3;
    localparam logic [3:0] ACT_BYTE_DONE = 4'd4;
    localparam logic [3:0] ACT_STOP      = 4'd5;
    localparam logic [3:0] ACT_NACK      = 4'd6;
    localparam logic [3:0] ACT_BUS_ERR   = 4'd7;
    localparam logic [3:0] ACT_STATUS    = 4'd8;

    localparam logic [3:0] KIND_NONE      = 4'd0;
    localparam logic [3:0] KIND_LIGHT_RST = 4'd1;
    localparam logic [3:0] KIND_HARD_RST  = 4'd2;
    localparam logic [3:0] KIND_USB0      = 4'd3;
    localparam logic [3:0] KIND_USB1      = 4'd4;
    localparam logic [3:0] KIND_REGULATOR = 4'd5;
    localparam logic [3:0] KIND_BTN_MODE  = 4'd6;
    localparam logic [3:0] KIND_BOOTLOAD  = 4'd7;
    localparam logic [3:0] KIND_LED_MODE  = 4'd8;
    localparam logic [3:0] KIND_LED_STATE = 4'd9;
    localparam logic [3:0] KIND_COLOUR    = 4'd10;
    localparam logic [3:0] KIND_VOLTAGE   = 4'd11;
    localparam logic [3:0] KIND_BRIGHT    = 4'd12;
    localparam logic [3:0] KIND_WDG_STATE = 4'd13;
    localparam logic [3:0] KIND_WDG_PERS  = 4'd14;
    localparam logic [3:0] KIND_CNT_DEC   = 4'd15;

    localparam logic [7:0] CMD_GET_STATUS  = 8'h01;
    localparam logic [7:0] CMD_GEN_CTRL    = 8'h02;
    localparam logic [7:0] CMD_LEDS_MODE   = 8'h03;
    localparam logic [7:0] CMD_LEDS_STATE  = 8'h04;
    localparam logic [7:0] CMD_COLOUR      = 8'h05;
    localparam logic [7:0] CMD_VOLTAGE     = 8'h06;
    localparam logic [7:0] CMD_BRIGHT      = 8'h07;
    localparam logic [7:0] CMD_GET_BRIGHT  = 8'h08;
    localparam logic [7:0] CMD_RESET_CAUSE = 8'h09;
    localparam logic [7:0] CMD_APP_VER     = 8'h0A;
    localparam logic [7:0] CMD_WDG_STATE   = 8'h0B;
    localparam logic [7:0] CMD_WDG_PERS    = 8'h0C;
    localparam logic [7:0] CMD_GET_WDG     = 8'h0D;
    localparam logic [7:0] CMD_BOOT_VER    = 8'h0E;

    localparam int ST_USB0        = 5;
    localparam int ST_USB1        = 6;
    localparam int ST_4V5         = 7;
    localparam int ST_BTN_MODE    = 8;
    localparam int ST_BTN_PRESSED = 9;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [3:0]  cmd_kind;
        logic [3:0]  cmd_target;
        logic [23:0] cmd_value;
        logic        rx_overflow;
    } t_result;

    typedef struct packed {
        logic [NSLOT-1:0]           vld;
        t_result [NSLOT-1:0]        slot;
    } t_bundle;

    localparam logic [7:0] VER_ROM [2*VER_LEN] = '{
        8'h3a, 8'h51, 8'h0c, 8'h9e, 8'h27, 8'hb4, 8'h68, 8'h13, 8'hf0, 8'h4d,
        8'h82, 8'h5f, 8'h16, 8'hc9, 8'h7a, 8'h30, 8'he5, 8'h09, 8'hab, 8'h64,
        8'h1b, 8'hd2, 8'h47, 8'h8e, 8'h55, 8'h6c, 8'h03, 8'hfa, 8'h91, 8'h2e,
        8'hb7, 8'h40, 8'hcd, 8'h18, 8'h7f, 8'he2, 8'h36, 8'h9b, 8'h04, 8'h5a
    };

    function automatic logic [7:0] ver_byte(input logic [5:0] idx);
        logic [7:0] v;
        v = 8'hff;
        if (idx < 6'(2*VER_LEN)) begin
            v = VER_ROM[idx];
        end
        return v;
    endfunction

    function automatic t_result mk_cmd(input logic [3:0] kind, input logic [3:0] target,
                                       input logic [23:0] value);
        t_result r;
        r             = '0;
        r.cmd_kind    = kind;
        r.cmd_target  = target;
        r.cmd_value   = value;
        return r;
    endfunction

endpackage

### design/i2cd_core.sv
// ----------------------------------------------------------------------------
// I2C command decoder core
// Holds bus phase, receive and transmit stores and the status word, and turns
// one bus event into a bundle of up to five results.
// ----------------------------------------------------------------------------
module i2cd_core #(
    parameter int RX_DEPTH = 8,
    parameter int TX_DEPTH = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [3:0]         i_action,
    input  logic [7:0]         i_data_byte,
    input  logic [15:0]        i_status_mask,
    input  logic [15:0]        i_status_value,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output i2cd_pkg::t_bundle  o_bundle
);
    import i2cd_pkg::*;

    localparam int CW = $clog2(RX_DEPTH + 1);
    localparam int RW = $clog2(TX_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_STOPPED, PH_RECEIVING, PH_TRANSMITTING, PH_TRANSMITTED
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_rx [RX_KEEP];
    logic [7:0]  n_rx [RX_KEEP];
    logic [CW-1:0] r_rx_count, n_rx_count;
    logic [7:0]  r_tx0, n_tx0, r_tx1, n_tx1;
    logic        r_ver_loaded, n_ver_loaded, r_ver_boot, n_ver_boot;
    logic [6:0]  r_tx_pos, n_tx_pos;
    logic [RW-1:0] r_tx_rem, n_tx_rem;
    logic [15:0] r_status, n_status;
    logic [7:0]  r_wdg, n_wdg, r_bright, n_bright;
    logic [7:0]  r_reset_kind;
    logic        r_reg_present;

    t_bundle     bundle;
    logic [7:0]  e [RX_KEEP];
    logic [7:0]  tx_out;
    logic [5:0]  ver_idx;
    logic [5:0]  ver_base;
    logic [CW-1:0] n_cnt;

    always_comb begin
        ver_idx = (r_ver_boot ? 6'(VER_LEN) : 6'd0) + r_tx_pos[5:0];
        tx_out  = 8'hff;
        if (r_tx_pos < 7'(TX_DEPTH)) begin
            if (r_tx_pos == 7'd0) begin
                tx_out = r_tx0;
            end else if (r_tx_pos == 7'd1) begin
                tx_out = r_tx1;
            end else if (!r_ver_loaded) begin
                tx_out = 8'h00;
            end else if (r_tx_pos < 7'(VER_LEN)) begin
                tx_out = ver_byte(ver_idx);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < RX_KEEP; k++) begin
            e[k] = (r_rx_count == CW'(k)) ? i_data_byte : r_rx[k];
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_rx         = r_rx;
        n_rx_count   = r_rx_count;
        n_tx0        = r_tx0;
        n_tx1        = r_tx1;
        n_ver_loaded = r_ver_loaded;
        n_ver_boot   = r_ver_boot;
        n_tx_pos     = r_tx_pos;
        n_tx_rem     = r_tx_rem;
        n_status     = r_status;
        n_wdg        = r_wdg;
        n_bright     = r_bright;
        bundle       = '0;
        n_cnt        = r_rx_count + CW'(1);
        ver_base     = 6'd0;

        case (i_action)
            ACT_ADDR_RX: begin
                n_phase    = PH_RECEIVING;
                n_rx_count = '0;
            end
            ACT_ADDR_TX: begin
                n_phase    = PH_TRANSMITTING;
                n_rx_count = '0;
            end
            ACT_RX_BYTE: begin
                if (r_phase == PH_RECEIVING) begin
                    if (r_rx_count >= CW'(RX_DEPTH)) begin
                        bundle.vld[0]              = 1'b1;
                        bundle.slot[0].rx_overflow = 1'b1;
                    end else begin
                        n_rx       = e;
                        n_rx_count = n_cnt;
                        unique case (e[0])
                            CMD_GET_STATUS: begin
                                n_tx0      = r_status[7:0];
                                n_tx1      = r_status[15:8];
                                n_tx_rem   = RW'(2);
                                n_rx_count = '0;
                                n_status[ST_BTN_PRESSED] = 1'b0;
                                bundle.vld[0]  = 1'b1;
                                bundle.slot[0] = mk_cmd(KIND_CNT_DEC, 4'd0,
                                                        24'(r_status[15:13]));
                            end
                            CMD_GEN_CTRL: begin
                                if (n_cnt == CW'(3)) begin
                                    n_rx_count = '0;
                                    if (e[1][0] && e[2][0]) begin
                                        bundle.vld[0]  = 1'b1;
                                        bundle.slot[0] = mk_cmd(KIND_LIGHT_RST, 4'd0, 24'd0);
                                    end else if (e[1][1] && e[2][1]) begin
                                        bundle.vld[0]  = 1'b1;
                                        bundle.slot[0] = mk_cmd(KIND_HARD_RST, 4'd0, 24'd0);
                                    end else begin
                                        if (e[1][3]) begin
                                            n_status[ST_USB0] = e[2][3];
                                            bundle.vld[0]  = 1'b1;
                                            bundle.slot[0] = mk_cmd(KIND_USB0, 4'd0,
                                                                    24'(e[2][3]));
                                        end
                                        if (e[1][4]) begin
                                            n_status[ST_USB1] = e[2][4];
                                            bundle.vld[1]  = 1'b1;
                                            bundle.slot[1] = mk_cmd(KIND_USB1, 4'd0,
                                                                    24'(e[2][4]));
                                        end
                                        if (r_reg_present && e[1][5]) begin
                                            if (!e[2][5]) begin
                                                n_status[ST_4V5] = 1'b0;
                                            end
                                            bundle.vld[2]  = 1'b1;
                                            bundle.slot[2] = mk_cmd(KIND_REGULATOR, 4'd0,
                                                                    24'(e[2][5]));
                                        end
                                        if (e[1][6]) begin
                                            n_status[ST_BTN_MODE] = e[2][6];
                                            bundle.vld[3]  = 1'b1;
                                            bundle.slot[3] = mk_cmd(KIND_BTN_MODE, 4'd0,
                                                                    24'(e[2][6]));
                                        end
                                        if (e[1][7] && e[2][7]) begin
                                            bundle.vld[4]  = 1'b1;
                                            bundle.slot[4] = mk_cmd(KIND_BOOTLOAD, 4'd0,
                                                                    24'd1);
                                        end
                                    end
                                end
                            end
                            CMD_LEDS_MODE, CMD_LEDS_STATE: begin
                                if (n_cnt == CW'(2)) begin
                                    n_rx_count     = '0;
                                    bundle.vld[0]  = 1'b1;
                                    bundle.slot[0] = mk_cmd(
                                        (e[0] == CMD_LEDS_MODE) ? KIND_LED_MODE : KIND_LED_STATE,
                                        e[1][3:0], 24'(e[1][4]));
                                end
                            end
                            CMD_COLOUR: begin
                                if (n_cnt == CW'(5)) begin
                                    n_rx_count     = '0;
                                    bundle.vld[0]  = 1'b1;
                                    bundle.slot[0] = mk_cmd(KIND_COLOUR, e[1][3:0],
                                                            {e[2], e[3], e[4]});
                                end
                            end
                            CMD_VOLTAGE: begin
                                if (!r_reg_present) begin
                                    n_rx_count = '0;
                                end else if (n_cnt == CW'(2)) begin
                                    n_rx_count     = '0;
                                    bundle.vld[0]  = 1'b1;
                                    bundle.slot[0] = mk_cmd(KIND_VOLTAGE, 4'd0, 24'(e[1]));
                                end
                            end
                            CMD_BRIGHT: begin
                                if (n_cnt == CW'(2)) begin
                                    n_rx_count     = '0;
                                    n_bright       = e[1];
                                    bundle.vld[0]  = 1'b1;
                                    bundle.slot[0] = mk_cmd(KIND_BRIGHT, 4'd0, 24'(e[1]));
                                end
                            end
                            CMD_GET_BRIGHT: begin
                                n_tx0      = r_bright;
                                n_tx_rem   = RW'(1);
                                n_rx_count = '0;
                            end
                            CMD_RESET_CAUSE: begin
                                n_tx0      = r_reset_kind;
                                n_tx_rem   = RW'(1);
                                n_rx_count = '0;
                            end
                            CMD_APP_VER, CMD_BOOT_VER: begin
                                ver_base     = (e[0] == CMD_BOOT_VER) ? 6'(VER_LEN) : 6'd0;
                                n_tx0        = ver_byte(ver_base);
                                n_tx1        = ver_byte(ver_base + 6'd1);
                                n_ver_loaded = 1'b1;
                                n_ver_boot   = (e[0] == CMD_BOOT_VER);
                                n_tx_rem     = RW'(TX_DEPTH);
                                n_rx_count   = '0;
                            end
                            CMD_WDG_STATE: begin
                                if (n_cnt == CW'(2)) begin
                                    n_rx_count     = '0;
                                    n_wdg          = e[1];
                                    bundle.vld[0]  = 1'b1;
                                    bundle.slot[0] = mk_cmd(KIND_WDG_STATE, 4'd0, 24'(e[1]));
                                end
                            end
                            CMD_WDG_PERS: begin
                                if (n_cnt == CW'(2)) begin
                                    n_rx_count     = '0;
                                    bundle.vld[0]  = 1'b1;
                                    bundle.slot[0] = mk_cmd(KIND_WDG_PERS, 4'd0, 24'(e[1]));
                                end
                            end
                            CMD_GET_WDG: begin
                                n_tx0      = r_wdg;
                                n_tx_rem   = RW'(1);
                                n_rx_count = '0;
                            end
                            default: begin
                                n_rx_count = '0;
                            end
                        endcase
                    end
                end
            end
            ACT_TX_EMPTY: begin
                if (r_phase == PH_TRANSMITTING) begin
                    if (r_tx_rem != '0) begin
                        bundle.vld[0]           = 1'b1;
                        bundle.slot[0].tx_valid = 1'b1;
                        bundle.slot[0].tx_byte  = tx_out;
                        if (r_tx_pos != 7'd127) begin
                            n_tx_pos = r_tx_pos + 7'd1;
                        end
                        n_tx_rem = r_tx_rem - RW'(1);
                    end
                    if (n_tx_rem == '0) begin
                        n_tx_pos = 7'd0;
                        n_phase  = PH_TRANSMITTED;
                    end
                end
            end
            ACT_BYTE_DONE: begin
                if (r_phase == PH_TRANSMITTED) begin
                    bundle.vld[0]           = 1'b1;
                    bundle.slot[0].tx_valid = 1'b1;
                    bundle.slot[0].tx_byte  = 8'hff;
                end
            end
            ACT_STOP, ACT_NACK, ACT_BUS_ERR: begin
                if (r_phase != PH_STOPPED || i_action != ACT_STOP) begin
                    n_tx_pos = 7'd0;
                    n_tx_rem = '0;
                    n_phase  = PH_STOPPED;
                end
            end
            ACT_STATUS: begin
                n_status = (r_status & ~i_status_mask) | (i_status_value & i_status_mask);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_STOPPED;
            r_rx_count    <= '0;
            r_tx_pos      <= '0;
            r_tx_rem      <= '0;
            r_status      <= '0;
            r_wdg         <= '0;
            r_bright      <= '0;
            r_ver_loaded  <= 1'b0;
            r_reset_kind  <= '0;
            r_reg_present <= 1'b1;
        end else begin
            if (i_take) begin
                r_phase      <= n_phase;
                r_rx_count   <= n_rx_count;
                r_tx_pos     <= n_tx_pos;
                r_tx_rem     <= n_tx_rem;
                r_status     <= n_status;
                r_wdg        <= n_wdg;
                r_bright     <= n_bright;
                r_ver_loaded <= n_ver_loaded;
            end
            if (i_cfg_we) begin
                if (i_cfg_index) begin
                    r_reg_present <= i_cfg_data[0];
                end else begin
                    r_reset_kind <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_rx       <= n_rx;
            r_tx0      <= n_tx0;
            r_tx1      <= n_tx1;
            r_ver_boot <= n_ver_boot;
        end
    end

    assign o_bundle = bundle;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_count <= CW'(RX_DEPTH))
        else $error("receive count beyond depth");
    a_transmitted_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TRANSMITTED) |-> (r_tx_rem == '0 && r_tx_pos == 7'd0))
        else $error("transmitted phase with bytes left");
    a_stopped_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && (i_action == ACT_NACK || i_action == ACT_BUS_ERR))
        |=> (r_phase == PH_STOPPED && r_tx_rem == '0))
        else $error("nack or bus error did not stop");

endmodule

### design/i2cd_emit.sv
// ----------------------------------------------------------------------------
// I2C command decoder result queue
// Holds the results of one event and hands them out one per transfer.
// ----------------------------------------------------------------------------
module i2cd_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  i2cd_pkg::t_bundle  i_bundle,
    output logic               o_busy,
    output logic               o_valid,
    input  logic               i_stall,
    output i2cd_pkg::t_result  o_result,
    output logic               o_last
);
    import i2cd_pkg::*;

    logic [NSLOT-1:0] r_vld;
    t_result          r_slot [NSLOT];
    logic [NSLOT-1:0] sel;
    logic             out_take;

    always_comb begin
        sel      = '0;
        o_result = r_slot[0];
        for (int k = NSLOT - 1; k >= 0; k--) begin
            if (r_vld[k]) begin
                sel      = '0;
                sel[k]   = 1'b1;
                o_result = r_slot[k];
            end
        end
    end

    assign o_valid  = |r_vld;
    assign o_last   = (r_vld & ~sel) == '0;
    assign out_take = o_valid && !i_stall;
    assign o_busy   = o_valid && !(out_take && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_take) begin
            r_vld <= i_bundle.vld;
        end else if (out_take) begin
            r_vld <= r_vld & ~sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            for (int k = 0; k < NSLOT; k++) begin
                r_slot[k] <= i_bundle.slot[k];
            end
        end
    end

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !i_take)
        else $error("event taken while results pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall && !i_take) |=> $stable(r_vld))
        else $error("pending results changed under stall");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && o_last && !i_take) |=> !o_valid)
        else $error("result left after final transfer");

endmodule

### design/i2c_slave_command_decoder.sv
// ----------------------------------------------------------------------------
// I2C slave command decoder
// Decodes I2C slave bus events into command results and transmit bytes.
// ----------------------------------------------------------------------------
// Results of an event are registered and appear in the cycle after it is accepted.
// Throughput: one event per cycle when it gives at most one result; an event
// with N results stalls the input while the result queue drains, and for
// every cycle in which the receiver stalls a result.
// Reset: synchronous, active low; phase stopped, counts and status cleared,
// regulator_present set to 1. No clearing pass is needed.
module i2c_slave_command_decoder #(
    parameter int RX_DEPTH = 8,
    parameter int TX_DEPTH = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_status_mask,
    input  logic [15:0] i_status_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic [3:0]  o_cmd_kind,
    output logic [3:0]  o_cmd_target,
    output logic [23:0] o_cmd_value,
    output logic        o_rx_overflow,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import i2cd_pkg::*;

    t_bundle bundle;
    t_result result;
    logic    busy;
    logic    take;

    assign take       = i_in_valid && !busy;
    assign o_in_stall = busy;

    i2cd_core #(
        .RX_DEPTH(RX_DEPTH),
        .TX_DEPTH(TX_DEPTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_action      (i_action),
        .i_data_byte   (i_data_byte),
        .i_status_mask (i_status_mask),
        .i_status_value(i_status_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_bundle      (bundle)
    );

    i2cd_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_bundle(bundle),
        .o_busy  (busy),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_result(result),
        .o_last  (o_last)
    );

    assign o_tx_valid    = result.tx_valid;
    assign o_tx_byte     = result.tx_byte;
    assign o_cmd_kind    = result.cmd_kind;
    assign o_cmd_target  = result.cmd_target;
    assign o_cmd_value   = result.cmd_value;
    assign o_rx_overflow = result.rx_overflow;

endmodule
